[hw/rtl/chte_pkg.sv]
// Package: shared constants, types and hash functions of the cuckoo hash engine
package chte_pkg;

   // Slots per table; a power of two, so a hash reduces to its low bits.
   localparam int unsigned SLOTS_PER_TABLE           = 512;
   localparam int unsigned MAX_DISPLACEMENTS_DEFAULT = 50;

   localparam logic [31:0] MIX1_MULT = 32'h27d4eb2d;
   localparam logic [31:0] MIX1_SALT = 32'd61;
   localparam logic [31:0] MIX2_MULT = 32'h045d9f3b;

   localparam logic [1:0] KIND_SEARCH = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] key;
      logic [31:0] value;
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH1,
      ST_HASH2,
      ST_HASH3,
      ST_RD,
      ST_LOOK,
      ST_WHASH1,
      ST_WHASH2,
      ST_WHASH3,
      ST_WRD,
      ST_WLOOK,
      ST_MOVE_RD,
      ST_MOVE_LD,
      ST_MOVE_WR,
      ST_PLACE,
      ST_RESP
   } state_type;

   // Pre-multiply parts of the first mix.
   function automatic logic [31:0] mix1_pre(input logic [31:0] k);
      logic [31:0] t;
      t = (k ^ MIX1_SALT) ^ (k >> 16);
      t = t + (t << 3);
      t = t ^ (t >> 4);
      return t;
   endfunction

   function automatic logic [31:0] mix_post15(input logic [31:0] k);
      return k ^ (k >> 15);
   endfunction

   function automatic logic [31:0] fold16(input logic [31:0] k);
      return k ^ (k >> 16);
   endfunction

endpackage

[hw/rtl/chte_if.sv]
// Interfaces: valid/ready channels of the cuckoo hash engine
interface chte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] lookup_key;
   logic [31:0] data_value;
   modport source (output valid, kind, lookup_key, data_value, input ready);
   modport sink   (input valid, kind, lookup_key, data_value, output ready);
endinterface

interface chte_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] read_value;
   logic        status;
   modport source (output valid, hit, read_value, status, input ready);
   modport sink   (input valid, hit, read_value, status, output ready);
endinterface

[hw/rtl/chte_front.sv]
// Front end: accept transactions and queue them for the table engine
module chte_front #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   chte_req_if.sink          req,
   output chte_pkg::op_type  op_out,
   output logic              op_valid,
   input  logic              op_take
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   chte_pkg::op_type  mem_ff [DEPTH];
   logic [AW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign req.ready = (cnt_ff < (AW+1)'(DEPTH));
   assign push      = req.valid && req.ready;
   assign op_valid  = (cnt_ff != '0);
   assign pop       = op_valid && op_take;
   assign op_out    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ((wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? ((rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= '{kind: req.kind, key: req.lookup_key, value: req.data_value};
      end
   end
endmodule

[hw/rtl/chte_back.sv]
// Back end: hash, look up, update and displace entries in the two tables
module chte_back #(
   parameter int unsigned MAX_DISPLACEMENTS = chte_pkg::MAX_DISPLACEMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  chte_pkg::op_type  op_in,
   input  logic              op_valid,
   output logic              op_take,
   chte_rsp_if.source        rsp
);
   localparam int unsigned SLOTS = chte_pkg::SLOTS_PER_TABLE;
   localparam int unsigned IW  = $clog2(SLOTS);
   localparam int unsigned FW  = IW + 1;
   localparam int unsigned NS  = 2 * SLOTS;
   localparam int unsigned PW  = $clog2(MAX_DISPLACEMENTS + 1);
   localparam int unsigned PD  = MAX_DISPLACEMENTS;
   localparam int unsigned PAW = (PD > 1) ? $clog2(PD) : 1;

   // Slot storage: flat index = table * SLOTS + index. The top bit of a key
   // word is the slot valid flag.
   logic [32:0]   keys_mem [NS];
   logic [31:0]   vals_mem [NS];
   logic [FW-1:0] path_mem [PD];

   chte_pkg::state_type state_ff, state_in;
   chte_pkg::op_type    op_ff;

   logic [31:0] h1_ff, h2_ff;       // hash pipeline for the item key
   logic [31:0] m1_ff, m2_ff;       // hash pipeline for walk keys
   logic [FW-1:0] a_ff, b_ff;
   logic [31:0] ka_ff, kb_ff, va_ff, vb_ff;
   logic        la_ff, lb_ff;
   logic [FW-1:0] cur_ff;
   logic          side_ff;
   logic [PW-1:0] n_ff;
   logic [PW-1:0] step_ff;
   logic [31:0]   wkey_ff;
   logic          wvalid_ff;
   logic [FW-1:0] src_ff;
   logic [31:0]   mk_ff, mv_ff;
   logic          hit_ff, status_ff;
   logic [31:0]   rval_ff;
   logic [FW-1:0] clr_ff;
   logic          rvld_ff, rvld_in;
   logic          out_hit_ff, out_status_ff;
   logic [31:0]   out_value_ff;

   logic in_a, in_b, walk, rsp_load;

   function automatic logic [IW-1:0] reduce(input logic [31:0] k);
      return k[IW-1:0];
   endfunction

   assign in_a = la_ff && (ka_ff == op_ff.key);
   assign in_b = !in_a && lb_ff && (kb_ff == op_ff.key);
   assign walk = (op_ff.kind == chte_pkg::KIND_INSERT) && !in_a && !in_b
                 && la_ff && lb_ff;

   // Load the output register once the previous response has left it.
   assign rsp_load = (state_ff == chte_pkg::ST_RESP) && (!rvld_ff || rsp.ready);
   assign rvld_in  = rsp_load || (rvld_ff && !rsp.ready);

   assign op_take    = (state_ff == chte_pkg::ST_IDLE) && op_valid;
   assign rsp.valid      = rvld_ff;
   assign rsp.hit        = out_hit_ff;
   assign rsp.read_value = out_value_ff;
   assign rsp.status     = out_status_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chte_pkg::ST_CLEAR:   if (clr_ff == FW'(NS - 1)) state_in = chte_pkg::ST_IDLE;
         chte_pkg::ST_IDLE:    if (op_valid) state_in = chte_pkg::ST_HASH1;
         chte_pkg::ST_HASH1:   state_in = chte_pkg::ST_HASH2;
         chte_pkg::ST_HASH2:   state_in = chte_pkg::ST_HASH3;
         chte_pkg::ST_HASH3:   state_in = chte_pkg::ST_RD;
         chte_pkg::ST_RD:      state_in = chte_pkg::ST_LOOK;
         chte_pkg::ST_LOOK: begin
            if (walk)
               state_in = chte_pkg::ST_WRD;
            else
               state_in = chte_pkg::ST_RESP;
         end
         chte_pkg::ST_WRD:     state_in = chte_pkg::ST_WLOOK;
         chte_pkg::ST_WLOOK: begin
            if (step_ff == PW'(MAX_DISPLACEMENTS)) state_in = chte_pkg::ST_RESP;
            else if (!wvalid_ff) state_in = (n_ff == '0) ? chte_pkg::ST_PLACE
                                                         : chte_pkg::ST_MOVE_RD;
            else state_in = chte_pkg::ST_WHASH1;
         end
         chte_pkg::ST_WHASH1:  state_in = chte_pkg::ST_WHASH2;
         chte_pkg::ST_WHASH2:  state_in = chte_pkg::ST_WHASH3;
         chte_pkg::ST_WHASH3:  state_in = chte_pkg::ST_WRD;
         chte_pkg::ST_MOVE_RD: state_in = chte_pkg::ST_MOVE_LD;
         chte_pkg::ST_MOVE_LD: state_in = chte_pkg::ST_MOVE_WR;
         chte_pkg::ST_MOVE_WR: state_in = (n_ff == '0) ? chte_pkg::ST_PLACE
                                                       : chte_pkg::ST_MOVE_RD;
         chte_pkg::ST_PLACE:   state_in = chte_pkg::ST_RESP;
         chte_pkg::ST_RESP:    if (rsp_load) state_in = chte_pkg::ST_IDLE;
         default:              state_in = chte_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= chte_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rvld_ff <= 1'b0;
      end else begin
         rvld_ff <= rvld_in;
      end
      if (rsp_load) begin
         out_hit_ff    <= hit_ff;
         out_value_ff  <= rval_ff;
         out_status_ff <= status_ff;
      end
   end

   // Datapath and tables.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         case (state_ff)
            chte_pkg::ST_CLEAR: begin
               keys_mem[clr_ff] <= '0;
               clr_ff <= clr_ff + 1'b1;
            end
            chte_pkg::ST_IDLE: begin
               op_ff <= op_in;
               hit_ff <= 1'b0;
               status_ff <= 1'b0;
               rval_ff <= '0;
            end
            chte_pkg::ST_HASH1: begin
               h1_ff <= chte_pkg::mix1_pre(op_ff.key);
               h2_ff <= chte_pkg::fold16(op_ff.key) * chte_pkg::MIX2_MULT;
            end
            chte_pkg::ST_HASH2: begin
               h1_ff <= h1_ff * chte_pkg::MIX1_MULT;
               h2_ff <= chte_pkg::fold16(h2_ff) * chte_pkg::MIX2_MULT;
            end
            chte_pkg::ST_HASH3: begin
               a_ff <= {1'b0, reduce(chte_pkg::mix_post15(h1_ff))};
               b_ff <= {1'b1, reduce(chte_pkg::fold16(h2_ff))};
            end
            chte_pkg::ST_RD: begin
               ka_ff <= keys_mem[a_ff][31:0];  la_ff <= keys_mem[a_ff][32];
               va_ff <= vals_mem[a_ff];
               kb_ff <= keys_mem[b_ff][31:0];  lb_ff <= keys_mem[b_ff][32];
               vb_ff <= vals_mem[b_ff];
            end
            chte_pkg::ST_LOOK: begin
               cur_ff  <= a_ff;
               side_ff <= 1'b0;
               n_ff    <= '0;
               step_ff <= '0;
               case (op_ff.kind)
                  chte_pkg::KIND_SEARCH: begin
                     hit_ff <= in_a || in_b;
                     if (in_a) rval_ff <= va_ff;
                     else if (in_b) rval_ff <= vb_ff;
                  end
                  chte_pkg::KIND_INSERT: begin
                     hit_ff <= in_a || in_b;
                     if (in_a) vals_mem[a_ff] <= op_ff.value;
                     else if (in_b) vals_mem[b_ff] <= op_ff.value;
                     else if (!la_ff) begin
                        keys_mem[a_ff] <= {1'b1, op_ff.key};
                        vals_mem[a_ff] <= op_ff.value;
                     end else if (!lb_ff) begin
                        keys_mem[b_ff] <= {1'b1, op_ff.key};
                        vals_mem[b_ff] <= op_ff.value;
                     end
                  end
                  chte_pkg::KIND_REMOVE: begin
                     hit_ff <= in_a || in_b;
                     if (in_a) keys_mem[a_ff] <= {1'b0, ka_ff};
                     else if (in_b) keys_mem[b_ff] <= {1'b0, kb_ff};
                  end
                  default: ;
               endcase
            end
            chte_pkg::ST_WRD: begin
               wkey_ff   <= keys_mem[cur_ff][31:0];
               wvalid_ff <= keys_mem[cur_ff][32];
            end
            chte_pkg::ST_WLOOK: begin
               if (step_ff == PW'(MAX_DISPLACEMENTS)) begin
                  status_ff <= 1'b1;
               end else if (wvalid_ff) begin
                  path_mem[n_ff[PAW-1:0]] <= cur_ff;
                  n_ff    <= n_ff + 1'b1;
                  step_ff <= step_ff + 1'b1;
                  side_ff <= ~side_ff;
               end
            end
            chte_pkg::ST_WHASH1: begin
               m1_ff <= chte_pkg::mix1_pre(wkey_ff);
               m2_ff <= chte_pkg::fold16(wkey_ff) * chte_pkg::MIX2_MULT;
            end
            chte_pkg::ST_WHASH2: begin
               m1_ff <= m1_ff * chte_pkg::MIX1_MULT;
               m2_ff <= chte_pkg::fold16(m2_ff) * chte_pkg::MIX2_MULT;
            end
            chte_pkg::ST_WHASH3: begin
               if (side_ff) cur_ff <= {1'b1, reduce(chte_pkg::fold16(m2_ff))};
               else         cur_ff <= {1'b0, reduce(chte_pkg::mix_post15(m1_ff))};
            end
            chte_pkg::ST_MOVE_RD: begin
               src_ff <= path_mem[PAW'(n_ff - 1'b1)];
               n_ff   <= n_ff - 1'b1;
            end
            chte_pkg::ST_MOVE_LD: begin
               mk_ff <= keys_mem[src_ff][31:0];
               mv_ff <= vals_mem[src_ff];
            end
            chte_pkg::ST_MOVE_WR: begin
               // The source slot is rewritten by the next move or by the
               // final placement, so it needs no separate clear.
               keys_mem[cur_ff] <= {1'b1, mk_ff};
               vals_mem[cur_ff] <= mv_ff;
               cur_ff <= src_ff;
            end
            chte_pkg::ST_PLACE: begin
               keys_mem[a_ff] <= {1'b1, op_ff.key};
               vals_mem[a_ff] <= op_ff.value;
            end
            default: ;
         endcase
      end
   end
endmodule

[hw/rtl/cuckoo_hash_table_engine_core.sv]
// Top level: two-table cuckoo hash engine for 32-bit keys and values
// Each request transaction (search, insert/update, remove) yields exactly one
// response transaction, in order. A small queue takes requests while the table
// engine works; the engine handles one transaction at a time. After reset the
// engine clears the valid flags of all 2*SLOTS_PER_TABLE slots (1024 by default),
// one slot per cycle; the queue still takes up to two requests in that time.
// For search, remove and simple inserts the engine takes the request in
// ST_IDLE, hashes in ST_HASH1 to ST_HASH3 with a register after each multiply,
// reads both tables in ST_RD, decides in ST_LOOK and loads the response
// register in ST_RESP. An insert that walks the displacement path adds ST_WRD
// and ST_WLOOK to read and check each examined slot, ST_WHASH1 to ST_WHASH3 to
// hash each occupant it follows, ST_MOVE_RD, ST_MOVE_LD and ST_MOVE_WR per
// moved entry and ST_PLACE to place the new key; a walk that finds no free slot
// gives up after MAX_DISPLACEMENTS occupants. The response register lets the
// engine start the next transaction while a response waits for ready; a second
// finished response holds the engine until the first one leaves.
module cuckoo_hash_table_engine_core #(
   parameter int unsigned MAX_DISPLACEMENTS = chte_pkg::MAX_DISPLACEMENTS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   chte_req_if.sink   req,
   chte_rsp_if.source rsp
);
   chte_pkg::op_type op;
   logic             op_valid, op_take;

   // Front: buffer incoming transactions.
   chte_front #(.DEPTH(2)) u_front (
      .clock, .reset, .req,
      .op_out(op), .op_valid, .op_take
   );

   // Back: execute against the tables and hold the response.
   chte_back #(
      .MAX_DISPLACEMENTS(MAX_DISPLACEMENTS)
   ) u_back (
      .clock, .reset,
      .op_in(op), .op_valid, .op_take, .rsp
   );
endmodule
